### rtl/ahsf_pkg.sv
// Package for the assignment hash seen filter.
// Holds key-folding and mixing constants, command and outcome codes and shared types.
// No dependencies.
`default_nettype none

package ahsf_pkg;

  localparam logic [63:0] FOLD_START = 64'h1234_5678_9ABC_DEF0;
  localparam logic [63:0] GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_ONE    = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0] MIX_TWO    = 64'hBF58_476D_1CE4_E5B9;

  localparam int VAR_COUNT = 32;
  localparam int VAR_W     = 5;

  localparam logic CMD_PROBE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [2:0] OUT_PRESENT    = 3'd0;
  localparam logic [2:0] OUT_PLACED_ONE = 3'd1;
  localparam logic [2:0] OUT_PLACED_TWO = 3'd2;
  localparam logic [2:0] OUT_OVERWROTE  = 3'd3;
  localparam logic [2:0] OUT_CLEARED    = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

### rtl/ahsf_hash.sv
// Slot hash unit: 64-bit mix (one 32x32 multiplier reused for each partial product)
// and a reduction modulo half the table size by reciprocal multiplication.
// Depends on ahsf_pkg.
`default_nettype none

module ahsf_hash #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic                             sel,
  input  logic [63:0]                      key,
  output logic                             done,
  output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);
  import ahsf_pkg::*;

  localparam int SLOT_W    = $clog2(TABLE_ENTRIES);
  localparam int HALF      = TABLE_ENTRIES / 2;
  localparam int RED_SHIFT = 32 + $clog2(HALF);
  localparam logic [32:0] RECIP    = 33'((65'd1 << RED_SHIFT) / 65'(HALF));
  localparam logic [31:0] HALF_W   = 32'(HALF);
  localparam logic [31:0] WORD_MOD = 32'((64'd1 << 32) % 64'(HALF));
  localparam logic [3:0] MUL_LAST = 4'd2;
  localparam logic [3:0] MOD_LAST = 4'd6;
  localparam logic [SLOT_W-1:0] HALF_S = SLOT_W'(HALF);

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_MUL  = 3'd1;
  localparam logic [2:0] H_MIX  = 3'd2;
  localparam logic [2:0] H_MOD  = 3'd3;
  localparam logic [2:0] H_DONE = 3'd4;

  logic [2:0]        state;
  logic [3:0]        step;
  logic [63:0]       x;
  logic [63:0]       acc;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W-1:0] hi_rem;
  logic [31:0]       red_v;
  logic [31:0]       quot;
  logic [64:0]       recip_prod;
  logic [31:0]       red_diff;
  logic [31:0]       red_fix;
  logic [31:0]       fold_sum;
  logic [63:0]       mc;
  logic [63:0]       pre_mix;
  logic [63:0]       post_mix;
  logic [31:0]       op_a;
  logic [31:0]       op_b;
  logic [63:0]       prod;

  assign mc       = sel ? MIX_TWO : MIX_ONE;
  assign pre_mix  = sel ? (key ^ (key >> 30)) : (key ^ (key >> 33));
  assign post_mix = sel ? (acc ^ (acc >> 27)) : (acc ^ (acc >> 33));

  // Low 64 bits of x * mc: lo*lo, then the two cross terms into the top half
  assign op_a = (step == 4'd1) ? x[63:32] : x[31:0];
  assign op_b = (step == 4'd2) ? mc[63:32] : mc[31:0];
  assign prod = op_a * op_b;

  // Estimated quotient is exact or one low, so one conditional subtract fixes it
  assign recip_prod = {33'd0, red_v} * {32'd0, RECIP};
  assign red_diff   = red_v - (quot * HALF_W);
  assign red_fix    = (red_diff >= HALF_W) ? (red_diff - HALF_W) : red_diff;
  assign fold_sum   = (32'(hi_rem) * WORD_MOD) + 32'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      step  <= 4'd0;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (go) begin
            state <= H_MUL;
            step  <= 4'd0;
          end
        end
        H_MUL: begin
          step <= step + 4'd1;
          if (step == MUL_LAST) begin
            state <= H_MIX;
          end
        end
        H_MIX: begin
          state <= H_MOD;
          step  <= 4'd0;
        end
        H_MOD: begin
          step <= step + 4'd1;
          if (step == MOD_LAST) begin
            state <= H_DONE;
          end
        end
        H_DONE: state <= H_IDLE;
        default: state <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (go) begin
          x <= pre_mix;
        end
      end
      H_MUL: begin
        if (step == 4'd0) begin
          acc <= prod;
        end else begin
          acc[63:32] <= acc[63:32] + prod[31:0];
        end
      end
      H_MIX: begin
        x     <= post_mix;
        red_v <= post_mix[63:32];
      end
      H_MOD: begin
        // reduce the high word, then the low word, then hi_rem * (2^32 mod half) + lo_rem
        quot <= 32'(recip_prod >> RED_SHIFT);
        case (step)
          4'd1: begin
            hi_rem <= red_fix[SLOT_W-1:0];
            red_v  <= x[31:0];
          end
          4'd3: rem <= red_fix[SLOT_W-1:0];
          4'd4: red_v <= fold_sum;
          4'd6: rem <= red_fix[SLOT_W-1:0];
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign done = (state == H_DONE);
  assign slot = sel ? (HALF_S + rem) : rem;

endmodule

`default_nettype wire

### rtl/ahsf_queue.sv
// Short job queue between the front end and the table back end.
// Depends on ahsf_pkg for depth and status type.
`default_nettype none

module ahsf_queue #(
  parameter int W = 82
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [W-1:0]           wdata,
  input  logic                   pop,
  output logic [W-1:0]           rdata,
  output ahsf_pkg::fifo_stat_t   stat
);
  import ahsf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [W-1:0]     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  assign rdata      = entries[rd_ptr];
  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

### rtl/ahsf_front.sv
// Front end: accepts commands; for a probe it folds the assignment into a key one
// variable a cycle and runs both slot hashes; pushes the job. Depends on ahsf_pkg, ahsf_hash.
`default_nettype none

module ahsf_front #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic                                        hold,
  input  logic                                        cmd,
  input  logic [31:0]                                 assigned_mask,
  input  logic [31:0]                                 value_bits,
  output logic                                        busy,
  output logic                                        q_push,
  output logic [1+64+2*$clog2(TABLE_ENTRIES)-1:0]     q_data,
  input  ahsf_pkg::fifo_stat_t                        q_stat
);
  import ahsf_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam logic [VAR_W-1:0] VAR_LAST = VAR_W'(VAR_COUNT - 1);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_FOLD = 3'd1;
  localparam logic [2:0] F_KICK = 3'd2;
  localparam logic [2:0] F_HASH = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]        state;
  logic [VAR_W-1:0]  cnt;
  logic [31:0]       mask;
  logic [31:0]       vals;
  logic [63:0]       key;
  logic [63:0]       gold;
  logic              job_cmd;
  logic [SLOT_W-1:0] slot_a;
  logic [SLOT_W-1:0] slot_b;
  logic              accept;
  logic              hash_go;
  logic [63:0]       key_odd;
  logic              done_a;
  logic              done_b;
  logic [SLOT_W-1:0] hslot_a;
  logic [SLOT_W-1:0] hslot_b;

  assign busy    = (state != F_IDLE) || hold;
  assign accept  = start && !busy;
  assign hash_go = (state == F_KICK);
  assign q_push  = (state == F_PUSH) && !q_stat.full;
  assign key_odd = key | 64'd1;
  assign q_data  = {job_cmd, key_odd, slot_a, slot_b};

  ahsf_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash_one (
    .clk  (clk),
    .rst  (rst),
    .go   (hash_go),
    .sel  (1'b0),
    .key  (key_odd),
    .done (done_a),
    .slot (hslot_a)
  );

  ahsf_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash_two (
    .clk  (clk),
    .rst  (rst),
    .go   (hash_go),
    .sel  (1'b1),
    .key  (key_odd),
    .done (done_b),
    .slot (hslot_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= (cmd == CMD_CLEAR) ? F_PUSH : F_FOLD;
          end
        end
        F_FOLD: begin
          cnt <= cnt + 1'b1;
          if (cnt == VAR_LAST) begin
            state <= F_KICK;
          end
        end
        F_KICK: state <= F_HASH;
        F_HASH: begin
          if (done_a && done_b) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_push) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          job_cmd <= cmd;
          mask    <= assigned_mask;
          vals    <= value_bits;
          key     <= FOLD_START;
          gold    <= GOLDEN;
        end
      end
      F_FOLD: begin
        // skip unassigned variables, but keep the weight advancing
        if (mask[0]) begin
          key <= ((key ^ (gold + {63'd0, vals[0]})) << 7)
               | ((key ^ (gold + {63'd0, vals[0]})) >> 57);
        end
        gold <= gold + GOLDEN;
        mask <= mask >> 1;
        vals <= vals >> 1;
      end
      F_HASH: begin
        if (done_a && done_b) begin
          slot_a <= hslot_a;
          slot_b <= hslot_b;
        end
      end
      default: begin
      end
    endcase
  end

  a_hash_lockstep: assert property (@(posedge clk) disable iff (rst)
    done_a == done_b)
    else $error("slot hash units out of step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("front end not busy after accepting an item");

endmodule

`default_nettype wire

### rtl/ahsf_back.sv
// Back end: owns the key table, probes and inserts one job at a time,
// runs clearing passes and drives the result. Depends on ahsf_pkg.
`default_nettype none

module ahsf_back #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [1+64+2*$clog2(TABLE_ENTRIES)-1:0]     q_rdata,
  input  ahsf_pkg::fifo_stat_t                        q_stat,
  output logic                                        q_pop,
  output logic                                        init_busy,
  output logic                                        done,
  output logic                                        is_new,
  output logic [2:0]                                  outcome
);
  import ahsf_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int QW     = 1 + 64 + 2 * SLOT_W;
  localparam logic [SLOT_W-1:0] ADDR_LAST = SLOT_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] B_INIT  = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_CHECK = 2'd2;
  localparam logic [1:0] B_CLEAR = 2'd3;

  logic [63:0]       mem [TABLE_ENTRIES];
  logic [1:0]        state;
  logic [SLOT_W-1:0] clr_addr;
  logic              h_cmd;
  logic [63:0]       h_key;
  logic [SLOT_W-1:0] h_a;
  logic [SLOT_W-1:0] h_b;
  logic [63:0]       key;
  logic [SLOT_W-1:0] slot_a;
  logic [SLOT_W-1:0] slot_b;
  logic [63:0]       rd_a;
  logic [63:0]       rd_b;
  logic              hit;
  logic              free_a;
  logic              free_b;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [63:0]       wdata;
  logic [2:0]        code;
  logic              done_next;

  assign h_cmd = q_rdata[QW-1];
  assign h_key = q_rdata[QW-2 -: 64];
  assign h_a   = q_rdata[2*SLOT_W-1 -: SLOT_W];
  assign h_b   = q_rdata[SLOT_W-1:0];

  assign q_pop     = (state == B_IDLE) && !q_stat.empty;
  assign init_busy = (state == B_INIT);

  assign hit    = (rd_a == key) || (rd_b == key);
  assign free_a = (rd_a == 64'd0);
  assign free_b = (rd_b == 64'd0);

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = 64'd0;
    code  = OUT_PRESENT;
    unique case (state)
      B_INIT, B_CLEAR: begin
        we   = 1'b1;
        code = OUT_CLEARED;
      end
      B_CHECK: begin
        wdata = key;
        if (hit) begin
          code = OUT_PRESENT;
        end else if (free_a) begin
          we    = 1'b1;
          waddr = slot_a;
          code  = OUT_PLACED_ONE;
        end else if (free_b) begin
          we    = 1'b1;
          waddr = slot_b;
          code  = OUT_PLACED_TWO;
        end else begin
          we    = 1'b1;
          waddr = slot_a;
          code  = OUT_OVERWROTE;
        end
      end
      default: begin
      end
    endcase
  end

  assign done_next = (state == B_CHECK) || ((state == B_CLEAR) && (clr_addr == ADDR_LAST));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[h_a];
    rd_b <= mem[h_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_INIT;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        B_INIT, B_CLEAR: begin
          if (clr_addr == ADDR_LAST) begin
            clr_addr <= '0;
            state    <= B_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            clr_addr <= '0;
            state    <= (h_cmd == CMD_CLEAR) ? B_CLEAR : B_CHECK;
          end
        end
        B_CHECK: state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      key    <= h_key;
      slot_a <= h_a;
      slot_b <= h_b;
    end
    if (done_next) begin
      outcome <= code;
      is_new  <= (state == B_CHECK) && !hit;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_is_new_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_new == ((outcome == OUT_PLACED_ONE) || (outcome == OUT_PLACED_TWO)
                        || (outcome == OUT_OVERWROTE))))
    else $error("is_new disagrees with outcome");

  a_check_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHECK) |-> $past(q_pop))
    else $error("probe check without a popped job");

endmodule

`default_nettype wire

### rtl/assignment_hash_seen_filter.sv
// Top level of the assignment hash seen filter (two-choice hash set of folded keys).
// Depends on ahsf_pkg, ahsf_front, ahsf_queue, ahsf_back.
//
//   channel   handshake       payload
//   command   start / busy    cmd, assigned_mask, value_bits
//   result    done (strobe)   is_new, outcome
//
// A probe passes through the front end's one-variable-per-cycle key fold, the
// split 64-bit multiply, the reciprocal modulo and the push into the job queue,
// which waits while the queue is full; the back end then checks it and strobes.
// A clear skips the fold and hashes and is pushed directly; the back end sweeps
// all TABLE_ENTRIES entries and strobes its result once the sweep ends.
// After reset busy stays high through a clearing pass over all TABLE_ENTRIES entries.
// Results cannot be held off; the two-deep job queue lets the front end fold
// the next item while the back end is still sweeping.
`default_nettype none

module assignment_hash_seen_filter #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [31:0] assigned_mask,
  input  logic [31:0] value_bits,
  output logic        done,
  output logic        is_new,
  output logic [2:0]  outcome
);
  import ahsf_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int QW     = 1 + 64 + 2 * SLOT_W;

  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  fifo_stat_t    q_stat;
  logic          init_busy;

  ahsf_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .hold          (init_busy),
    .cmd           (cmd),
    .assigned_mask (assigned_mask),
    .value_bits    (value_bits),
    .busy          (busy),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_stat        (q_stat)
  );

  ahsf_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ahsf_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .done      (done),
    .is_new    (is_new),
    .outcome   (outcome)
  );

endmodule

`default_nettype wire

### bench/tb_assignment_hash_seen_filter.sv
// Self-checking bench for assignment_hash_seen_filter: folds, probes and clears a mirror
// key table per accepted item and compares every strobed result in order.
// Depends on ahsf_pkg and the RTL of the filter.
module tb_assignment_hash_seen_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import ahsf_pkg::*;

  localparam int TABLE_ENTRIES = 1024;
  localparam logic [63:0] HALF = 64'(TABLE_ENTRIES / 2);
  localparam int PHASE_ITEMS = 495;
  localparam int PHASE_PACE[4] = '{0, 64, 11, 0};

  typedef struct {
    logic        cmd;
    logic [31:0] mask;
    logic [31:0] vals;
  } assign_item_t;

  typedef struct {
    logic       is_new;
    logic [2:0] outcome;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cmd = CMD_PROBE;
  logic [31:0] assigned_mask = '0;
  logic [31:0] value_bits = '0;
  logic        busy;
  logic        done;
  logic        is_new;
  logic [2:0]  outcome;

  assign_item_t assign_backlog[$];
  assign_item_t recent_assigns[$];
  verdict_t     owed_verdicts[$];
  logic [63:0]  key_table[TABLE_ENTRIES];
  int           idle_pct = 0;
  int           mismatches = 0;
  int           accepted = 0;
  int           outcome_tally[5] = '{default: 0};

  assignment_hash_seen_filter #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .assigned_mask(assigned_mask),
    .value_bits   (value_bits),
    .done         (done),
    .is_new       (is_new),
    .outcome      (outcome)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] fold_assignment(logic [31:0] m, logic [31:0] v);
    logic [63:0] h;
    h = FOLD_START;
    for (int n = 1; n <= 32; n++) begin
      if (m[n-1]) begin
        h = h ^ ((64'(n) * GOLDEN) + {63'd0, v[n-1]});
        h = {h[56:0], h[63:57]};
      end
    end
    return h;
  endfunction

  function automatic int slot_lo(logic [63:0] x);
    x = x ^ (x >> 33);
    x = x * MIX_ONE;
    x = x ^ (x >> 33);
    return int'(x % HALF);
  endfunction

  function automatic int slot_hi(logic [63:0] x);
    x = x ^ (x >> 30);
    x = x * MIX_TWO;
    x = x ^ (x >> 27);
    return int'(HALF + (x % HALF));
  endfunction

  // Mirror one item on the key table and return the result it must produce.
  function automatic verdict_t probe_and_insert(logic c, logic [31:0] m, logic [31:0] v);
    verdict_t    r;
    logic [63:0] key;
    int          a;
    int          b;
    if (c == CMD_CLEAR) begin
      foreach (key_table[i]) key_table[i] = '0;
      r.is_new = 1'b0;
      r.outcome = OUT_CLEARED;
      return r;
    end
    key = fold_assignment(m, v) | 64'd1;
    a = slot_lo(key);
    b = slot_hi(key);
    if (key_table[a] == key || key_table[b] == key) begin
      r.is_new = 1'b0;
      r.outcome = OUT_PRESENT;
    end else begin
      r.is_new = 1'b1;
      if (key_table[a] == '0) begin
        key_table[a] = key;
        r.outcome = OUT_PLACED_ONE;
      end else if (key_table[b] == '0) begin
        key_table[b] = key;
        r.outcome = OUT_PLACED_TWO;
      end else begin
        key_table[a] = key;
        r.outcome = OUT_OVERWROTE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_item(input logic c, input logic [31:0] m, input logic [31:0] v);
    assign_item_t it;
    it.cmd = c;
    it.mask = m;
    it.vals = v;
    assign_backlog = {assign_backlog, it};
    if (c == CMD_PROBE) begin
      recent_assigns = {recent_assigns, it};
      if (recent_assigns.size() > 256) void'(recent_assigns.pop_front());
    end
  endtask

  // Mix of revisits, sparse masks and wide random assignments, with rare clears.
  task automatic queue_random_item();
    assign_item_t h;
    logic [31:0]  m;
    logic [31:0]  v;
    int           pick;
    pick = $urandom_range(299);
    if (pick == 0) begin
      queue_item(CMD_CLEAR, $urandom, $urandom);
    end else if (pick < 110 && recent_assigns.size() != 0) begin
      h = recent_assigns[$urandom_range(recent_assigns.size() - 1)];
      v = h.vals;
      // scramble unassigned value bits; the key must not change
      if ($urandom_range(1)) v = v ^ (~h.mask & $urandom);
      queue_item(CMD_PROBE, h.mask, v);
    end else if (pick < 160) begin
      m = '0;
      repeat ($urandom_range(3)) m[$urandom_range(31)] = 1'b1;
      queue_item(CMD_PROBE, m, $urandom);
    end else begin
      queue_item(CMD_PROBE, $urandom, $urandom);
    end
  endtask

  task automatic drain();
    while (assign_backlog.size() != 0 || start !== 1'b0 || owed_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // Driver: hold an item until busy is low, then load the next one or idle.
  always @(posedge clk) begin : drive
    assign_item_t nxt;
    verdict_t     due;
    logic         free;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due = probe_and_insert(cmd, assigned_mask, value_bits);
        owed_verdicts = {owed_verdicts, due};
        accepted++;
      end
      free = !start || !busy;
      if (free) begin
        if (assign_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = assign_backlog.pop_front();
          start <= 1'b1;
          cmd <= nxt.cmd;
          assigned_mask <= nxt.mask;
          value_bits <= nxt.vals;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobe retires the oldest outstanding verdict.
  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst && done === 1'b1) begin
      if (owed_verdicts.size() == 0) begin
        report_mismatch($sformatf("result strobe with no item outstanding (outcome %0d)",
                                  outcome));
      end else begin
        want = owed_verdicts.pop_front();
        if (is_new !== want.is_new)
          report_mismatch($sformatf("is_new %b, predicted %b", is_new, want.is_new));
        if (outcome !== want.outcome)
          report_mismatch($sformatf("outcome %0d, predicted %0d", outcome, want.outcome));
      end
      if (outcome <= OUT_CLEARED) outcome_tally[outcome]++;
    end
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    foreach (key_table[i]) key_table[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, ignored value bits, clears
    queue_item(CMD_PROBE, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_PROBE, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(CMD_PROBE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(CMD_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_PROBE, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
    queue_item(CMD_PROBE, 32'hFFFF_FFFF, 32'h5555_5555);
    queue_item(CMD_PROBE, 32'h0000_0001, 32'h0000_0000);
    queue_item(CMD_PROBE, 32'h0000_0001, 32'h0000_0001);
    queue_item(CMD_PROBE, 32'h8000_0000, 32'h0000_0000);
    queue_item(CMD_PROBE, 32'h8000_0000, 32'h8000_0000);
    queue_item(CMD_PROBE, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_item(CMD_PROBE, 32'hAAAA_AAAA, 32'h0000_0000);
    queue_item(CMD_PROBE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_PROBE, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_PROBE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_PROBE, 32'h0000_0000, 32'h0000_0000);
    drain();

    foreach (PHASE_PACE[p]) begin
      idle_pct = PHASE_PACE[p];
      repeat (PHASE_ITEMS) queue_random_item();
      drain();
    end

    repeat (TABLE_ENTRIES + 64) @(negedge clk);
    $display("run covered %0d items at sender idle rates of 0, 64, 11 and 0 percent",
             accepted);
    $display("results: %0d present, %0d slot one, %0d slot two, %0d overwrites, %0d clears",
             outcome_tally[OUT_PRESENT], outcome_tally[OUT_PLACED_ONE],
             outcome_tally[OUT_PLACED_TWO], outcome_tally[OUT_OVERWROTE],
             outcome_tally[OUT_CLEARED]);
    if (mismatches == 0 && owed_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/ahsf_pkg.sv
rtl/ahsf_hash.sv
rtl/ahsf_queue.sv
rtl/ahsf_front.sv
rtl/ahsf_back.sv
rtl/assignment_hash_seen_filter.sv
bench/tb_assignment_hash_seen_filter.sv
